// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/mssr_pkg.sv =====
// Types, constants and helper functions of the motor soft start ramp.
`default_nettype none

package mssr_pkg;

	localparam int ThrW    = 10;
	localparam int PctW    = 7;
	localparam int DutyW   = 8;
	localparam int TimerW  = 10;
	localparam int SettleW = 12;
	localparam int CfgW    = 12;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_RAMP_INTERVAL = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_FORWARD   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_BACKWARD  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SETTLE_TICKS  = 2'd3;

	localparam logic [TimerW-1:0]  RST_RAMP_INTERVAL = 10'd30;
	localparam logic [PctW-1:0]    RST_MAX_FORWARD   = 7'd100;
	localparam logic [PctW-1:0]    RST_MAX_BACKWARD  = 7'd30;
	localparam logic [SettleW-1:0] RST_SETTLE_TICKS  = 12'd1500;

	localparam logic [PctW-1:0] FULL_PERCENT = 7'd100;

	// 255 * ceil(2^19 / 100): speed * 255 / 100 for speeds up to 100
	localparam int DutyRecipW = 21;
	localparam logic [DutyRecipW-1:0] DUTY_RECIP = 21'd1336965;
	localparam int DutyShift = 19;

	typedef struct packed {
		logic [TimerW-1:0]  ramp_interval;
		logic [PctW-1:0]    max_forward_percent;
		logic [PctW-1:0]    max_backward_percent;
		logic [SettleW-1:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [DutyW-1:0] pwm_duty;
		logic             drive_forward;
		logic [PctW-1:0]  speed_percent;
		logic [PctW-1:0]  target_percent;
		logic             halted;
	} result_t;

	function automatic logic [DutyW-1:0] duty_of(input logic [PctW-1:0] speed);
		logic [PctW+DutyRecipW-1:0] prod;
		prod = {{DutyRecipW{1'b0}}, speed} * {{PctW{1'b0}}, DUTY_RECIP};
		return prod[DutyShift +: DutyW];
	endfunction

endpackage

`default_nettype wire

// ===== sv/mssr_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
`default_nettype none

interface mssr_tick_if import mssr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ThrW-1:0] throttle_sample;
	logic            full_speed_test;
	logic            stop_test;
	logic            emergency_brake;
	logic            reverse_select;

	modport source (output valid, throttle_sample, full_speed_test, stop_test,
		emergency_brake, reverse_select, input ready);
	modport sink (input valid, throttle_sample, full_speed_test, stop_test,
		emergency_brake, reverse_select, output ready);
endinterface

interface mssr_result_if import mssr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DutyW-1:0] pwm_duty;
	logic             drive_forward;
	logic [PctW-1:0]  speed_percent;
	logic [PctW-1:0]  target_percent;
	logic             halted;

	modport source (output valid, pwm_duty, drive_forward, speed_percent,
		target_percent, halted, input ready);
	modport sink (input valid, pwm_duty, drive_forward, speed_percent,
		target_percent, halted, output ready);
endinterface

`default_nettype wire

// ===== sv/motor_soft_start_ramp.sv =====
// Motor soft start ramp: one tick in, one status result out.
// Each transfer on tick is one millisecond tick and yields exactly one result on status.
// A tick is registered on entry and its state update runs while it moves into the
// result register, so a new tick is taken every cycle unless status stalls.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while no tick is in flight; the block does not enforce this.
`default_nettype none

module motor_soft_start_ramp import mssr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mssr_tick_if.sink               tick,
	mssr_result_if.source           status,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_wdata
);

	`include "assert_macros.svh"

	cfg_t cfg_q;

	logic            valid_s1;
	logic [PctW-1:0] goal_s1;
	logic            want_forward_s1;
	logic            brake_s1;
	logic            valid_s2;
	result_t         res_s2;

	logic            advance;
	logic [PctW-1:0] goal_in;
	result_t         result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_interval        <= RST_RAMP_INTERVAL;
			cfg_q.max_forward_percent  <= RST_MAX_FORWARD;
			cfg_q.max_backward_percent <= RST_MAX_BACKWARD;
			cfg_q.settle_ticks         <= RST_SETTLE_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_INTERVAL: cfg_q.ramp_interval        <= cfg_wdata[TimerW-1:0];
				REG_MAX_FORWARD:   cfg_q.max_forward_percent  <= cfg_wdata[PctW-1:0];
				REG_MAX_BACKWARD:  cfg_q.max_backward_percent <= cfg_wdata[PctW-1:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks         <= cfg_wdata[SettleW-1:0];
				default: ;
			endcase
		end
	end

	mssr_target u_target (
		.throttle_sample (tick.throttle_sample),
		.full_speed_test (tick.full_speed_test),
		.stop_test       (tick.stop_test),
		.goal            (goal_in)
	);

	assign advance    = valid_s1 && (!valid_s2 || status.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			goal_s1         <= goal_in;
			want_forward_s1 <= !tick.reverse_select;
			brake_s1        <= tick.emergency_brake;
		end
	end

	mssr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.goal_new     (goal_s1),
		.want_forward (want_forward_s1),
		.brake        (brake_s1),
		.cfg          (cfg_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || status.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign status.valid          = valid_s2;
	assign status.pwm_duty       = res_s2.pwm_duty;
	assign status.drive_forward  = res_s2.drive_forward;
	assign status.speed_percent  = res_s2.speed_percent;
	assign status.target_percent = res_s2.target_percent;
	assign status.halted         = res_s2.halted;

	`ASSERT_ALWAYS(a_halt_no_drive, clk, arst_n,
		!valid_s2 || !res_s2.halted || (res_s2.speed_percent == '0 && res_s2.pwm_duty == '0))
	`ASSERT_ALWAYS(a_speed_range, clk, arst_n,
		!valid_s2 || res_s2.speed_percent <= FULL_PERCENT)
	`ASSERT_NEXT(a_advance_fills, clk, arst_n, advance, valid_s2)
	`ASSERT_NEXT(a_halt_sticks, clk, arst_n, valid_s2 && res_s2.halted && advance,
		res_s2.halted)

endmodule

`default_nettype wire

// ===== sv/mssr_target.sv =====
// Target speed selection from the throttle sample and the test switches.
`default_nettype none

module mssr_target import mssr_pkg::*; (
	input  wire logic [ThrW-1:0] throttle_sample,
	input  wire logic            full_speed_test,
	input  wire logic            stop_test,
	output logic      [PctW-1:0] goal
);

	localparam int ProdW = ThrW + PctW;

	logic [ProdW-1:0] scaled;
	logic [PctW-1:0]  quot_est;
	logic [ThrW:0]    rem_est;
	logic [PctW-1:0]  mapped;

	// divide by 1023: estimate with a shift, then correct by one
	always_comb begin
		scaled   = {{PctW{1'b0}}, throttle_sample} * ProdW'(FULL_PERCENT);
		quot_est = scaled[ThrW +: PctW];
		rem_est  = {1'b0, scaled[ThrW-1:0]} + {{(ThrW+1-PctW){1'b0}}, quot_est};
		mapped   = (rem_est >= (ThrW+1)'(10'd1023)) ? quot_est + 1'b1 : quot_est;
	end

	always_comb begin
		if (stop_test) begin
			goal = '0;
		end else if (full_speed_test) begin
			goal = FULL_PERCENT;
		end else begin
			goal = mapped;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mssr_core.sv =====
// Ramp, direction and halt state with its per-tick update.
`default_nettype none

module mssr_core import mssr_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic [PctW-1:0] goal_new,
	input  wire logic            want_forward,
	input  wire logic            brake,
	input  wire cfg_t            cfg,
	output result_t              result
);

	logic [PctW-1:0]    speed_q, speed_n;
	logic [PctW-1:0]    goal_q, goal_n;
	logic               heading_q, heading_n;
	logic [TimerW-1:0]  timer_q, timer_n;
	logic [SettleW-1:0] settle_q, settle_n;
	logic               pending_q, pending_n;
	logic               halt_q, halt_n;

	logic            heading_eff;
	logic [PctW-1:0] goal_eff;
	logic [PctW-1:0] limit;
	logic            do_ramp;
	logic            timer_inc;

	always_comb begin
		speed_n     = speed_q;
		goal_n      = goal_q;
		heading_n   = heading_q;
		timer_n     = timer_q;
		settle_n    = settle_q;
		pending_n   = pending_q;
		halt_n      = halt_q;
		heading_eff = heading_q;
		goal_eff    = goal_q;
		do_ramp     = 1'b0;
		timer_inc   = 1'b0;

		if (halt_q) begin
			halt_n = 1'b1;
		end else if (settle_q != '0) begin
			settle_n = settle_q - 1'b1;
			if (settle_q == SettleW'(1)) begin
				heading_n   = pending_q;
				heading_eff = pending_q;
				do_ramp     = 1'b1;
			end else begin
				timer_inc = 1'b1;
			end
		end else if (brake) begin
			halt_n  = 1'b1;
			speed_n = '0;
		end else begin
			goal_n   = goal_new;
			goal_eff = goal_new;
			if (speed_q == '0 && want_forward != heading_q) begin
				pending_n = want_forward;
				if (cfg.settle_ticks == '0) begin
					heading_n   = want_forward;
					heading_eff = want_forward;
					do_ramp     = 1'b1;
				end else begin
					settle_n = cfg.settle_ticks;
				end
			end else begin
				do_ramp = 1'b1;
			end
		end

		limit = heading_eff ? cfg.max_forward_percent : cfg.max_backward_percent;

		if (do_ramp) begin
			if (timer_q >= cfg.ramp_interval) begin
				timer_n = '0;
				if (speed_q < goal_eff && speed_q < limit) begin
					speed_n = speed_q + 1'b1;
				end else if (speed_q > goal_eff) begin
					speed_n = speed_q - 1'b1;
				end
			end else begin
				timer_inc = 1'b1;
			end
		end

		if (timer_inc && timer_q != '1) begin
			timer_n = timer_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= '0;
			goal_q    <= '0;
			heading_q <= 1'b1;
			timer_q   <= '0;
			settle_q  <= '0;
			pending_q <= 1'b1;
			halt_q    <= 1'b0;
		end else if (advance) begin
			speed_q   <= speed_n;
			goal_q    <= goal_n;
			heading_q <= heading_n;
			timer_q   <= timer_n;
			settle_q  <= settle_n;
			pending_q <= pending_n;
			halt_q    <= halt_n;
		end
	end

	always_comb begin
		result.pwm_duty       = duty_of(speed_n);
		result.drive_forward  = heading_n;
		result.speed_percent  = speed_n;
		result.target_percent = goal_n;
		result.halted         = halt_n;
	end

endmodule

`default_nettype wire
